// ===== hdl/bbd_pkg.sv =====
`default_nettype none
package bbd_pkg;

  // Frame geometry.
  localparam int IMG_WIDTH = 1024;
  localparam int COL_W = $clog2(IMG_WIDTH);
  localparam int CNT_W = $clog2(IMG_WIDTH + 2);
  localparam logic [COL_W-1:0] LAST_COL = COL_W'(IMG_WIDTH - 1);
  localparam logic [CNT_W-1:0] WARM_DONE = CNT_W'(IMG_WIDTH + 1);
  // Parity of the last column, used when the output pixel wraps to the previous row.
  localparam logic LAST_COL_ODD = LAST_COL[0];

  typedef logic [7:0] pixel_t;

  // One request as it travels from the address stage to the window stage.
  typedef struct packed {
    pixel_t           px;
    logic [COL_W-1:0] col;
    logic             row_odd;
    logic             first_row;
    logic             produce;
    logic             restart;
  } item_t;

endpackage
`default_nettype wire

// ===== hdl/bilinear_bayer_demosaic_core.sv =====
// Bilinear demosaic for a GBRG Bayer stream, one raw sample in and one RGB pixel out.
// Input channel: in_valid / in_stall with kind and pixel. kind = 0 is an image
// sample in raster order; kind = 1 is a flush request that enters as a zero sample.
// After each frame, send IMG_WIDTH+1 flush requests to push out the bottom row;
// that many flushes in a row return the position to the start of a frame.
// Output channel: out_valid / out_stall with red, green and blue.
// The first IMG_WIDTH+1 requests of a frame give no pixel; after that every
// request gives the pixel that arrived IMG_WIDTH+1 requests earlier.
// Throughput is one request per clock while the receiver does not stall. When the
// request that releases a result is accepted, the line memory read and the request
// register load; the output register loads as that request leaves the window stage.
// The two line stores share one dual-port memory, read at the incoming column and
// written back as the request leaves the window stage.
// When the receiver stalls, the output register holds its pixel and the request
// in the window stage waits; in_stall rises only while both are full.
// Reset clears the position, the window and the pipeline valid bits; the line
// memory needs no clearing because the first row of a frame never reads it.
`default_nettype none
module bilinear_bayer_demosaic_core
  import bbd_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   in_valid,
  output logic        in_stall,
  input  wire logic   kind,
  input  wire pixel_t pixel,
  output logic        out_valid,
  input  wire logic   out_stall,
  output pixel_t      red,
  output pixel_t      green,
  output pixel_t      blue
);

  logic             accept;
  logic             s1_valid;
  logic             s1_go;
  item_t            s1;
  item_t            item_next;
  logic [15:0]      rd_data;
  pixel_t           fresh_up;
  pixel_t           fresh_mid;
  logic [COL_W-1:0] col;
  logic [COL_W-1:0] col_next;
  logic             row_odd;
  logic             row_odd_next;
  logic             first_row;
  logic             first_row_next;
  logic [CNT_W-1:0] warm;
  logic [CNT_W-1:0] warm_next;
  logic [CNT_W-1:0] flush_run;
  logic [CNT_W-1:0] flush_run_next;
  logic             restart;
  logic             produce;

  // Handshake: the window stage moves on whenever the output register can take a pixel.
  assign s1_go    = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && out_valid && out_stall;
  assign accept   = in_valid && !in_stall;

  // Position tracking for the incoming request.
  assign produce = (warm >= WARM_DONE);
  assign restart = kind && (flush_run + CNT_W'(1) >= WARM_DONE);

  always_comb begin
    col_next       = (col == LAST_COL) ? '0 : col + COL_W'(1);
    row_odd_next   = (col == LAST_COL) ? ~row_odd : row_odd;
    first_row_next = (col == LAST_COL) ? 1'b0 : first_row;
    warm_next      = produce ? warm : warm + CNT_W'(1);
    flush_run_next = kind ? flush_run + CNT_W'(1) : '0;
    if (restart) begin
      col_next       = '0;
      row_odd_next   = 1'b0;
      first_row_next = 1'b1;
      warm_next      = '0;
      flush_run_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col       <= '0;
      row_odd   <= 1'b0;
      first_row <= 1'b1;
      warm      <= '0;
      flush_run <= '0;
    end else if (accept) begin
      col       <= col_next;
      row_odd   <= row_odd_next;
      first_row <= first_row_next;
      warm      <= warm_next;
      flush_run <= flush_run_next;
    end
  end

  // Request entering the window stage.
  always_comb begin
    item_next.px        = kind ? 8'd0 : pixel;
    item_next.col       = col;
    item_next.row_odd   = row_odd;
    item_next.first_row = first_row;
    item_next.produce   = produce;
    item_next.restart   = restart;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_go) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1 <= item_next;
    end
  end

  // Rows above the top of the frame read as zero.
  assign fresh_up  = s1.first_row ? 8'd0 : rd_data[15:8];
  assign fresh_mid = s1.first_row ? 8'd0 : rd_data[7:0];

  // Line memory: read at accept, write the shifted column back as the request leaves.
  bbd_line_mem u_mem (
    .clk     (clk),
    .rd_en   (accept),
    .rd_addr (col),
    .wr_en   (s1_go),
    .wr_addr (s1.col),
    .wr_data ({fresh_mid, s1.px}),
    .rd_data (rd_data)
  );

  bbd_window u_window (
    .clk       (clk),
    .rst       (rst),
    .advance   (s1_go),
    .item      (s1),
    .fresh_up  (fresh_up),
    .fresh_mid (fresh_mid),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .red       (red),
    .green     (green),
    .blue      (blue)
  );

endmodule
`default_nettype wire

// ===== hdl/bbd_line_mem.sv =====
`default_nettype none
module bbd_line_mem
  import bbd_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rd_en,
  input  wire logic [COL_W-1:0] rd_addr,
  input  wire logic             wr_en,
  input  wire logic [COL_W-1:0] wr_addr,
  input  wire logic [15:0]      wr_data,
  output logic      [15:0]      rd_data
);

  // Upper line in bits 15:8, middle line in bits 7:0.
  logic [15:0]  mem [IMG_WIDTH];
  logic [15:0]  mem_q;
  logic         byp;
  logic [15:0]  byp_data;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read; a write to the same entry in the same cycle is forwarded.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      mem_q    <= mem[rd_addr];
      byp      <= wr_en && (wr_addr == rd_addr);
      byp_data <= wr_data;
    end
  end

  assign rd_data = byp ? byp_data : mem_q;

endmodule
`default_nettype wire

// ===== hdl/bbd_window.sv =====
`default_nettype none
module bbd_window
  import bbd_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   advance,
  input  wire item_t  item,
  input  wire pixel_t fresh_up,
  input  wire pixel_t fresh_mid,
  input  wire logic   out_stall,
  output logic        out_valid,
  output pixel_t      red,
  output pixel_t      green,
  output pixel_t      blue
);

  pixel_t w0 [3];
  pixel_t w1 [3];
  pixel_t fresh [3];
  pixel_t lf [3];
  pixel_t rt [3];
  logic       col_zero;
  logic       col_one;
  logic       oc_odd;
  logic       orow_odd;
  logic [9:0] orth_sum;
  logic [9:0] diag_sum;
  logic [8:0] ns_sum;
  logic [8:0] we_sum;
  pixel_t     orth;
  pixel_t     diag;
  pixel_t     ns_avg;
  pixel_t     we_avg;
  pixel_t     cen;
  pixel_t     r_next;
  pixel_t     g_next;
  pixel_t     b_next;

  assign fresh[0] = fresh_up;
  assign fresh[1] = fresh_mid;
  assign fresh[2] = item.px;
  assign col_zero = (item.col == '0);
  assign col_one  = (item.col == COL_W'(1));

  // Edge columns read as zero.
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      rt[k] = col_zero ? 8'd0 : fresh[k];
      lf[k] = col_one  ? 8'd0 : w0[k];
    end
  end

  // Neighbor sums around the center sample.
  assign cen      = w1[1];
  assign orth_sum = {2'b00, w1[0]} + {2'b00, w1[2]} + {2'b00, lf[1]} + {2'b00, rt[1]};
  assign diag_sum = {2'b00, lf[0]} + {2'b00, lf[2]} + {2'b00, rt[0]} + {2'b00, rt[2]};
  assign ns_sum   = {1'b0, w1[0]} + {1'b0, w1[2]};
  assign we_sum   = {1'b0, lf[1]} + {1'b0, rt[1]};
  assign orth     = orth_sum[9:2];
  assign diag     = diag_sum[9:2];
  assign ns_avg   = ns_sum[8:1];
  assign we_avg   = we_sum[8:1];

  // The center is one column back, which wraps into the previous row at column zero.
  assign oc_odd   = col_zero ? LAST_COL_ODD : ~item.col[0];
  assign orow_odd = col_zero ? item.row_odd : ~item.row_odd;

  // Color selection for the GBRG mosaic.
  always_comb begin
    case ({orow_odd, oc_odd})
      2'b00: begin
        r_next = ns_avg; g_next = cen; b_next = we_avg;
      end
      2'b01: begin
        r_next = diag; g_next = orth; b_next = cen;
      end
      2'b10: begin
        r_next = cen; g_next = orth; b_next = diag;
      end
      default: begin
        r_next = we_avg; g_next = cen; b_next = ns_avg;
      end
    endcase
  end

  // Window shift; a frame restart clears it after the last flush request.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < 3; k++) begin
        w0[k] <= '0;
        w1[k] <= '0;
      end
    end else if (advance) begin
      for (int k = 0; k < 3; k++) begin
        w0[k] <= item.restart ? 8'd0 : w1[k];
        w1[k] <= item.restart ? 8'd0 : fresh[k];
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && item.produce) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && item.produce) begin
      red   <= r_next;
      green <= g_next;
      blue  <= b_next;
    end
  end

endmodule
`default_nettype wire

// ===== bench/bilinear_bayer_demosaic_checker.sv =====
`timescale 1ns / 100ps
module bilinear_bayer_demosaic_checker
  import bbd_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   in_valid,
  input  wire logic   in_stall,
  input  wire logic   kind,
  input  wire pixel_t pixel,
  input  wire logic   out_valid,
  input  wire logic   out_stall,
  input  wire pixel_t red,
  input  wire pixel_t green,
  input  wire pixel_t blue,
  output int          mismatches,
  output int          awaited,
  output int          compared
);

  typedef struct packed {
    pixel_t r;
    pixel_t g;
    pixel_t b;
  } rgb_t;

  // RGB pixels predicted but not yet seen on the output channel.
  rgb_t pending_rgb[$];

  // Local copy of the demosaic state.
  pixel_t           upper_row [IMG_WIDTH];
  pixel_t           middle_row[IMG_WIDTH];
  pixel_t           older_col [3];
  pixel_t           newer_col [3];
  logic [COL_W-1:0] col;
  logic             odd_row;
  logic             top_row;
  logic [CNT_W-1:0] warm;
  int               flush_len;

  initial begin
    mismatches = 0;
    awaited = 0;
    compared = 0;
  end

  // Return the position, window and warmup to the start of a frame.
  task automatic restart_frame();
    for (int i = 0; i < 3; i++) begin
      older_col[i] = '0;
      newer_col[i] = '0;
    end
    col = '0;
    odd_row = 1'b0;
    top_row = 1'b1;
    warm = '0;
  endtask

  // Advance the model by one accepted request and queue the pixel it releases.
  task automatic demosaic_step(input logic flush, input pixel_t raw);
    pixel_t           smp;
    pixel_t           fresh[3];
    pixel_t           lf[3];
    pixel_t           rt[3];
    logic [COL_W-1:0] oc;
    logic             orow;
    int               n, s, w, e, cen, orth, diag;
    rgb_t             px;
    smp = flush ? 8'd0 : raw;
    fresh[0] = top_row ? 8'd0 : upper_row[col];
    fresh[1] = top_row ? 8'd0 : middle_row[col];
    fresh[2] = smp;

    if (warm == WARM_DONE) begin
      for (int i = 0; i < 3; i++) begin
        rt[i] = (col == 0) ? 8'd0 : fresh[i];
        lf[i] = (col == 1) ? 8'd0 : older_col[i];
      end
      oc = (col == 0) ? LAST_COL : col - 1'b1;
      orow = (col == 0) ? odd_row : ~odd_row;
      n = newer_col[0];
      cen = newer_col[1];
      s = newer_col[2];
      w = lf[1];
      e = rt[1];
      orth = (n + s + w + e) / 4;
      diag = (lf[0] + lf[2] + rt[0] + rt[2]) / 4;
      // GBRG: even rows are G B, odd rows are R G.
      if (!orow) begin
        if (!oc[0]) begin
          px.r = pixel_t'((n + s) / 2);
          px.g = pixel_t'(cen);
          px.b = pixel_t'((w + e) / 2);
        end else begin
          px.r = pixel_t'(diag);
          px.g = pixel_t'(orth);
          px.b = pixel_t'(cen);
        end
      end else begin
        if (!oc[0]) begin
          px.r = pixel_t'(cen);
          px.g = pixel_t'(orth);
          px.b = pixel_t'(diag);
        end else begin
          px.r = pixel_t'((w + e) / 2);
          px.g = pixel_t'(cen);
          px.b = pixel_t'((n + s) / 2);
        end
      end
      pending_rgb.push_back(px);
    end else begin
      warm = warm + 1'b1;
    end

    upper_row[col] = fresh[1];
    middle_row[col] = smp;
    older_col = newer_col;
    newer_col = fresh;

    if (col == LAST_COL) begin
      col = '0;
      odd_row = ~odd_row;
      top_row = 1'b0;
    end else begin
      col = col + 1'b1;
    end

    // A full run of flushes closes the frame.
    if (flush) begin
      flush_len++;
      if (flush_len >= IMG_WIDTH + 1) begin
        flush_len = 0;
        restart_frame();
      end
    end else begin
      flush_len = 0;
    end
  endtask

  task automatic check_channel(input string name, input pixel_t want, input pixel_t got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  // Compare each accepted output pixel, then account for the accepted request.
  always @(posedge clk) begin
    rgb_t want;
    if (rst) begin
      pending_rgb.delete();
      restart_frame();
      flush_len = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (pending_rgb.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected pixel, expected none, actual r=%0d g=%0d b=%0d",
                   $time, red, green, blue);
        end else begin
          want = pending_rgb.pop_front();
          check_channel("red", want.r, red);
          check_channel("green", want.g, green);
          check_channel("blue", want.b, blue);
          compared++;
        end
      end
      if (in_valid && !in_stall) begin
        demosaic_step(kind, pixel);
      end
    end
    awaited = pending_rgb.size();
  end

endmodule

// ===== bench/bilinear_bayer_demosaic_core_tb.sv =====
`timescale 1ns / 100ps
module bilinear_bayer_demosaic_core_tb;
  import bbd_pkg::*;

  localparam int IDLE_PCT = 7;
  localparam int IDLE_LIMIT = 1000;

  logic   clk = 1'b0;
  logic   rst = 1'b1;
  logic   in_valid = 1'b0;
  logic   kind = 1'b0;
  pixel_t pixel = '0;
  logic   out_stall = 1'b0;
  logic   in_stall;
  logic   out_valid;
  pixel_t red, green, blue;

  // Turns idling off on both sides for a stretch.
  logic quiet = 1'b0;

  int mismatches, awaited, compared;
  int idle_cycles = 0;
  int pixels_sent = 0;
  int flushes_sent = 0;
  int frames_sent = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  bilinear_bayer_demosaic_core DUT (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .kind     (kind),
    .pixel    (pixel),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .red      (red),
    .green    (green),
    .blue     (blue)
  );

  bilinear_bayer_demosaic_checker rgb_check (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .kind      (kind),
    .pixel     (pixel),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .red       (red),
    .green     (green),
    .blue      (blue),
    .mismatches(mismatches),
    .awaited   (awaited),
    .compared  (compared)
  );

  // Random backpressure from the receiver.
  always @(posedge clk) begin
    out_stall <= !rst && !quiet && ($urandom_range(0, 99) < IDLE_PCT);
  end

  // Watchdog: too many cycles without any handshake ends the run.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Offer one request, with random gaps before it, and wait until it is taken.
  task automatic put_request(input logic flush, input pixel_t raw);
    logic held;
    while (!quiet && ($urandom_range(0, 99) < IDLE_PCT)) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    kind <= flush;
    pixel <= raw;
    do begin
      @(negedge clk);
      held = in_stall;
      @(posedge clk);
    end while (held);
    if (flush) begin
      flushes_sent++;
    end else begin
      pixels_sent++;
    end
  endtask

  // Raw samples weighted toward the extremes.
  function automatic pixel_t rand_pixel();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) return 8'h00;
    if (pick == 1) return 8'hFF;
    return pixel_t'($urandom_range(0, 255));
  endfunction

  task automatic send_flush(input int count);
    repeat (count) put_request(1'b1, pixel_t'($urandom_range(0, 255)));
  endtask

  // Image samples; with noise, short flush runs are mixed into the frame.
  task automatic send_image(input int count, input int noise_pct);
    for (int i = 0; i < count; i++) begin
      if (noise_pct > 0 && $urandom_range(0, 99) < noise_pct) begin
        send_flush($urandom_range(1, 6));
      end
      put_request(1'b0, rand_pixel());
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Opening frame: saturated, dark and alternating samples at the top-left
    // corner, and a flush in the middle of the first row whose sample is ignored.
    repeat (8) put_request(1'b0, 8'hFF);
    repeat (8) put_request(1'b0, 8'h00);
    for (int i = 0; i < 8; i++) begin
      put_request(1'b0, i[0] ? 8'hFF : 8'h00);
    end
    put_request(1'b1, 8'hFF);
    send_image(IMG_WIDTH - 25, 0);

    // Start of the second row at full rate on both sides.
    quiet <= 1'b1;
    send_image(128, 0);
    quiet <= 1'b0;

    // More of the second row with short flush runs mixed in, then the closing
    // run and one surplus flush that opens the next frame.
    send_image(48, 4);
    send_flush(IMG_WIDTH + 2);
    frames_sent++;
    in_valid <= 1'b0;

    while (awaited != 0) @(negedge clk);
    repeat (8) @(posedge clk);
    @(negedge clk);

    $display("Sent %0d image samples and %0d flush requests over %0d frames.",
             pixels_sent, flushes_sent, frames_sent);
    $display("Compared %0d RGB pixels, %0d mismatches.", compared, mismatches);
    if (mismatches == 0 && awaited == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
